[src/fcs_pkg.sv]
package fcs_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int DAC_OFFSET_DEF  = 8192;

  localparam int DAC_W      = 14;
  localparam int SP_W       = 13;
  localparam int FRAC_W     = 8;
  localparam int TICK_W     = 16;
  localparam int FLOW_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Deviation of a signed flow sample from the setpoint is held with two extra bits.
  localparam int DIFF_W  = FLOW_W + 2;
  localparam int DEV_W   = FLOW_W;
  localparam int LIM_W   = SP_W + FRAC_W;
  localparam int SCALE_W = DEV_W + FRAC_W;

  localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WARN_FRACTION  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FAULT_FRACTION = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_TIMEOUT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STABLE_TICKS   = 3'd4;

  localparam logic [SP_W-1:0]   SETPOINT_RST       = 13'd0;
  localparam logic [FRAC_W-1:0] WARN_FRACTION_RST  = 8'd26;
  localparam logic [FRAC_W-1:0] FAULT_FRACTION_RST = 8'd128;
  localparam logic [TICK_W-1:0] SETTLE_TIMEOUT_RST = 16'd10;
  localparam logic [TICK_W-1:0] STABLE_TICKS_RST   = 16'd3;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_STEP  = 2'd1,
    OP_STOP  = 2'd2,
    OP_START = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAGE_IDLE   = 2'd0,
    STAGE_ARMED  = 2'd1,
    STAGE_SETTLE = 2'd2,
    STAGE_RUN    = 2'd3
  } stage_t;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_REACHED = 2'd1,
    EV_STOPPED = 2'd2
  } event_t;

  typedef struct packed {
    logic [SP_W-1:0]   setpoint;
    logic [FRAC_W-1:0] warn_fraction;
    logic [FRAC_W-1:0] fault_fraction;
    logic [TICK_W-1:0] settle_timeout;
    logic [TICK_W-1:0] stable_ticks;
  } cfg_t;

  typedef struct packed {
    op_t                      op;
    logic                     valve_select;
    logic signed [FLOW_W-1:0] flow_measured;
    logic [DAC_W-1:0]         dac_readback;
  } item_t;

  typedef struct packed {
    logic             dac_write;
    logic [DAC_W-1:0] dac_value;
    logic             valve_zero_open;
    logic             valve_one_open;
    logic             flow_ready;
    logic             no_flow_alarm;
    logic             warn_alarm;
    logic             fault_alarm;
    event_t           event_code;
    stage_t           stage_now;
  } result_t;

endpackage

[src/fcs_cfg_regs.sv]
module fcs_cfg_regs
  import fcs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.setpoint       <= SETPOINT_RST;
      cfg.warn_fraction  <= WARN_FRACTION_RST;
      cfg.fault_fraction <= FAULT_FRACTION_RST;
      cfg.settle_timeout <= SETTLE_TIMEOUT_RST;
      cfg.stable_ticks   <= STABLE_TICKS_RST;
    end else if (wr_en) begin
      case (wr_index)
        CFG_SETPOINT:       cfg.setpoint       <= wr_data[SP_W-1:0];
        CFG_WARN_FRACTION:  cfg.warn_fraction  <= wr_data[FRAC_W-1:0];
        CFG_FAULT_FRACTION: cfg.fault_fraction <= wr_data[FRAC_W-1:0];
        CFG_SETTLE_TIMEOUT: cfg.settle_timeout <= wr_data[TICK_W-1:0];
        CFG_STABLE_TICKS:   cfg.stable_ticks   <= wr_data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

[src/fcs_seq.sv]
module fcs_seq
  import fcs_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
  parameter int DAC_OFFSET  = DAC_OFFSET_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  item_t   item,
  input  logic    item_fire,
  output result_t res
);

  localparam int CMP_W = (COUNT_WIDTH > TICK_W) ? COUNT_WIDTH : TICK_W;
  localparam logic [DAC_W-1:0] OFFSET_CODE = DAC_W'(DAC_OFFSET % (1 << DAC_W));
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  stage_t                 stage, stage_next;
  logic [COUNT_WIDTH-1:0] timeout_count, timeout_count_next;
  logic [COUNT_WIDTH-1:0] stable_count, stable_count_next;
  logic                   ready_flag, ready_flag_next;
  logic                   no_flow, no_flow_next;
  logic                   warn, warn_next;
  logic                   fault, fault_next;
  logic                   valve_zero, valve_zero_next;
  logic                   valve_one, valve_one_next;

  logic [DAC_W-1:0]         target;
  logic signed [DIFF_W-1:0] diff;
  logic [DEV_W-1:0]         dev;
  logic [SCALE_W-1:0]       dev_scaled;
  logic [LIM_W-1:0]         warn_lim;
  logic [LIM_W-1:0]         fault_lim;
  logic                     in_warn;
  logic                     below_fault;
  logic                     readback_ok;
  logic                     stable_done;
  logic                     timed_out;

  // Target wraps to the converter width, for writing and for comparison alike.
  assign target      = DAC_W'({1'b0, cfg.setpoint}) + OFFSET_CODE;
  assign readback_ok = (item.dac_readback == target);

  assign diff = {{2{item.flow_measured[FLOW_W-1]}}, item.flow_measured}
              - signed'({{(DIFF_W-SP_W){1'b0}}, cfg.setpoint});
  assign dev  = diff[DIFF_W-1] ? DEV_W'(-diff) : diff[DEV_W-1:0];

  // Tolerance test in Q0.8: dev*256 against setpoint*fraction, exact.
  assign dev_scaled  = {dev, {FRAC_W{1'b0}}};
  assign warn_lim    = LIM_W'(cfg.setpoint) * LIM_W'(cfg.warn_fraction);
  assign fault_lim   = LIM_W'(cfg.setpoint) * LIM_W'(cfg.fault_fraction);
  assign in_warn     = dev_scaled <= SCALE_W'(warn_lim);
  assign below_fault = dev_scaled <  SCALE_W'(fault_lim);

  assign stable_done = CMP_W'(stable_count)  > CMP_W'(cfg.stable_ticks);
  assign timed_out   = CMP_W'(timeout_count) > CMP_W'(cfg.settle_timeout);

  always_comb begin
    stage_next         = stage;
    timeout_count_next = timeout_count;
    stable_count_next  = stable_count;
    ready_flag_next    = ready_flag;
    no_flow_next       = no_flow;
    warn_next          = warn;
    fault_next         = fault;
    valve_zero_next    = valve_zero;
    valve_one_next     = valve_one;
    res.dac_write      = 1'b0;
    res.dac_value      = '0;
    res.event_code     = EV_NONE;

    case (item.op)
      OP_TICK: begin
        if (timeout_count != COUNT_MAX) timeout_count_next = timeout_count + 1'b1;
        if (stable_count != COUNT_MAX) stable_count_next = stable_count + 1'b1;
      end
      OP_START: begin
        stage_next = STAGE_ARMED;
      end
      OP_STOP: begin
        stage_next      = STAGE_IDLE;
        ready_flag_next = 1'b0;
        valve_zero_next = 1'b0;
        valve_one_next  = 1'b0;
        no_flow_next    = 1'b0;
        warn_next       = 1'b0;
        fault_next      = 1'b0;
        res.dac_write   = 1'b1;
        res.dac_value   = OFFSET_CODE;
        res.event_code  = EV_STOPPED;
      end
      OP_STEP: begin
        case (stage)
          STAGE_ARMED: begin
            res.dac_write      = 1'b1;
            res.dac_value      = target;
            valve_zero_next    = !item.valve_select;
            valve_one_next     = item.valve_select;
            ready_flag_next    = 1'b0;
            no_flow_next       = 1'b0;
            warn_next          = 1'b0;
            fault_next         = 1'b0;
            timeout_count_next = '0;
            stable_count_next  = '0;
            stage_next         = STAGE_SETTLE;
          end
          STAGE_SETTLE: begin
            if (!readback_ok) begin
              res.dac_write = 1'b1;
              res.dac_value = target;
            end else if (in_warn) begin
              if (stable_done) begin
                no_flow_next    = 1'b0;
                ready_flag_next = 1'b1;
                res.event_code  = EV_REACHED;
                stage_next      = STAGE_RUN;
              end
            end else begin
              stable_count_next = '0;
              if (timed_out) no_flow_next = 1'b1;
            end
          end
          STAGE_RUN: begin
            if (!readback_ok) begin
              res.dac_write = 1'b1;
              res.dac_value = target;
            end else begin
              warn_next  = !in_warn && below_fault;
              fault_next = !in_warn && !below_fault;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    res.valve_zero_open = valve_zero_next;
    res.valve_one_open  = valve_one_next;
    res.flow_ready      = ready_flag_next;
    res.no_flow_alarm   = no_flow_next;
    res.warn_alarm      = warn_next;
    res.fault_alarm     = fault_next;
    res.stage_now       = stage_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage         <= STAGE_IDLE;
      timeout_count <= '0;
      stable_count  <= '0;
      ready_flag    <= 1'b0;
      no_flow       <= 1'b0;
      warn          <= 1'b0;
      fault         <= 1'b0;
      valve_zero    <= 1'b0;
      valve_one     <= 1'b0;
    end else if (item_fire) begin
      stage         <= stage_next;
      timeout_count <= timeout_count_next;
      stable_count  <= stable_count_next;
      ready_flag    <= ready_flag_next;
      no_flow       <= no_flow_next;
      warn          <= warn_next;
      fault         <= fault_next;
      valve_zero    <= valve_zero_next;
      valve_one     <= valve_one_next;
    end
  end

endmodule

[src/flow_controller_supervisor_core.sv]
// Channel | Direction | Handshake            | Beat payload
// in      | in        | in_valid / in_ready   | op, valve_select, flow_measured, dac_readback
// out     | out       | out_valid / out_ready | dac_write .. stage_now (ten fields)
// cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One item per cycle sustained while out_ready stays high.
// Each beat passes through the input register and then the result register, with the whole
// supervisor step computed combinationally between them.
// Synchronous reset returns the sequencer to idle and the registers to defaults.
// A stall on out_ready holds the result; in_ready drops only when both registers are full.
// cfg_ready is always high; a write takes effect at the next edge.
module flow_controller_supervisor_core
  import fcs_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
  parameter int DAC_OFFSET  = DAC_OFFSET_DEF
) (
  input  logic                     clk,
  input  logic                     rst,

  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               op,
  input  logic                     valve_select,
  input  logic signed [FLOW_W-1:0] flow_measured,
  input  logic [DAC_W-1:0]         dac_readback,

  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     dac_write,
  output logic [DAC_W-1:0]         dac_value,
  output logic                     valve_zero_open,
  output logic                     valve_one_open,
  output logic                     flow_ready,
  output logic                     no_flow_alarm,
  output logic                     warn_alarm,
  output logic                     fault_alarm,
  output logic [1:0]               event_code,
  output logic [1:0]               stage_now,

  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data
);

  cfg_t    cfg;
  item_t   in_q;
  logic    in_full;
  logic    advance;
  result_t res;
  result_t res_q;

  assign cfg_ready = 1'b1;

  fcs_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // The buffered item moves on whenever the result register is free or draining.
  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q.op            <= op_t'(op);
      in_q.valve_select  <= valve_select;
      in_q.flow_measured <= flow_measured;
      in_q.dac_readback  <= dac_readback;
    end
  end

  fcs_seq #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .DAC_OFFSET  (DAC_OFFSET)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .item      (in_q),
    .item_fire (advance),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign dac_write       = res_q.dac_write;
  assign dac_value       = res_q.dac_value;
  assign valve_zero_open = res_q.valve_zero_open;
  assign valve_one_open  = res_q.valve_one_open;
  assign flow_ready      = res_q.flow_ready;
  assign no_flow_alarm   = res_q.no_flow_alarm;
  assign warn_alarm      = res_q.warn_alarm;
  assign fault_alarm     = res_q.fault_alarm;
  assign event_code      = res_q.event_code;
  assign stage_now       = res_q.stage_now;

endmodule

[src/fcs_checker.sv]
module fcs_checker
  import fcs_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             out_valid,
  input logic             out_ready,
  input logic             dac_write,
  input logic [DAC_W-1:0] dac_value,
  input logic             valve_zero_open,
  input logic             valve_one_open,
  input logic             flow_ready,
  input logic             warn_alarm,
  input logic             fault_alarm,
  input logic [1:0]       event_code,
  input logic [1:0]       stage_now
);

  // A stalled result beat must not change.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(dac_value) && $stable(stage_now))
    else $error("result changed while stalled");

  // Only one gas valve may be driven open at a time.
  a_one_valve: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(valve_zero_open && valve_one_open))
    else $error("both valves open");

  // A stop closes everything, writes the converter and returns to idle.
  a_stop: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_code == EV_STOPPED |->
      dac_write && !valve_zero_open && !valve_one_open && !flow_ready
      && !warn_alarm && !fault_alarm && stage_now == STAGE_IDLE)
    else $error("stop result inconsistent");

  // Flow reached always leaves the sequencer in the run stage with ready set.
  a_reached: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_code == EV_REACHED |-> flow_ready && stage_now == STAGE_RUN
      && !dac_write)
    else $error("flow reached without ready");

  a_class: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(warn_alarm && fault_alarm))
    else $error("warn and fault both set");

endmodule

bind flow_controller_supervisor_core fcs_checker u_fcs_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .dac_write       (dac_write),
  .dac_value       (dac_value),
  .valve_zero_open (valve_zero_open),
  .valve_one_open  (valve_one_open),
  .flow_ready      (flow_ready),
  .warn_alarm      (warn_alarm),
  .fault_alarm     (fault_alarm),
  .event_code      (event_code),
  .stage_now       (stage_now)
);
